/* sv/cbrt_pkg.sv */
package cbrt_pkg;

  // Default table size
  localparam int DEF_ENTRIES = 100;

  // Operation codes carried in the kind field
  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_DELETE = 2'd1;
  localparam logic [1:0] KIND_FIND   = 2'd2;

  // Input beat
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] card_id;
  } in_t;

  // Result beat
  typedef struct packed {
    logic        found;
    logic [31:0] serial_number;
  } out_t;

endpackage

/* sv/card_blocklist_ring_table_core.sv */
// Blocklist table of card ID and serial pairs, held in one RAM and filled as a ring.
// Operations scan the table through the RAM read port, one slot a cycle, one item at a time.
// From the accepting edge busy stays high through the scan, and for an insert also while
// the new entry is written; a find may end its scan early, at its lowest matching slot.
// The result strobe comes in the first cycle with busy low; the receiver cannot stall it.
// After reset the block clears every RAM slot with busy high.
module card_blocklist_ring_table_core #(
  parameter int ENTRIES = cbrt_pkg::DEF_ENTRIES
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  cbrt_pkg::in_t  in_data,
  output logic           out_valid,
  output cbrt_pkg::out_t out_data
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  typedef struct packed {
    logic [31:0] card_id;
    logic [31:0] serial;
  } entry_t;

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_SCAN, S_FINISH} state_t;

  state_t             state_r;
  cbrt_pkg::in_t      op_r;
  logic [CNT_W-1:0]   rd_idx_r;
  logic               chk_vld_r;
  logic [IDX_W-1:0]   chk_idx_r;
  logic [IDX_W-1:0]   write_slot_r;
  logic [IDX_W-1:0]   write_slot_nxt;
  logic [31:0]        serial_r;
  logic               out_valid_r;
  cbrt_pkg::out_t     out_data_r;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  entry_t             ram_wdata;
  entry_t             ram_rdata;
  logic               match;
  logic               scan_last;

  // The entry read last cycle is compared against the card ID of the operation.
  assign match     = chk_vld_r && (ram_rdata.card_id == op_r.card_id);
  assign scan_last = chk_vld_r && (chk_idx_r == LAST_IDX);
  assign write_slot_nxt = (write_slot_r == LAST_IDX) ? '0 : write_slot_r + 1'b1;

  // Write port: clearing sweep, clearing of matches, and the new entry of an insert.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = chk_idx_r;
    ram_wdata = '0;
    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = rd_idx_r[IDX_W-1:0];
      end
      S_SCAN: begin
        ram_we = match && (op_r.kind != cbrt_pkg::KIND_FIND);
      end
      S_FINISH: begin
        ram_we    = 1'b1;
        ram_waddr = write_slot_r;
        ram_wdata = '{card_id: op_r.card_id, serial: serial_r};
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  cbrt_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_idx_r[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  // Sequencer: state, scan pointers, ring pointer, serial counter and result beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      rd_idx_r     <= '0;
      chk_vld_r    <= 1'b0;
      write_slot_r <= '0;
      serial_r     <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_CLEAR: begin
          rd_idx_r <= rd_idx_r + 1'b1;
          if (rd_idx_r[IDX_W-1:0] == LAST_IDX) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start && (in_data.kind inside {cbrt_pkg::KIND_INSERT, cbrt_pkg::KIND_DELETE,
                                             cbrt_pkg::KIND_FIND})) begin
            op_r      <= in_data;
            rd_idx_r  <= '0;
            chk_vld_r <= 1'b0;
            state_r   <= S_SCAN;
          end
        end
        S_SCAN: begin
          // Issue one read a cycle until the whole table has been requested.
          if (rd_idx_r < CNT_W'(ENTRIES)) begin
            rd_idx_r  <= rd_idx_r + 1'b1;
            chk_vld_r <= 1'b1;
            chk_idx_r <= rd_idx_r[IDX_W-1:0];
          end else begin
            chk_vld_r <= 1'b0;
          end
          if (op_r.kind == cbrt_pkg::KIND_FIND) begin
            // A find stops at the lowest matching slot.
            if (match) begin
              out_valid_r <= 1'b1;
              out_data_r  <= '{found: 1'b1, serial_number: ram_rdata.serial};
              state_r     <= S_IDLE;
            end else if (scan_last) begin
              out_valid_r <= 1'b1;
              out_data_r  <= '{found: 1'b0, serial_number: 32'd0};
              state_r     <= S_IDLE;
            end
          end else if (scan_last) begin
            if (op_r.kind == cbrt_pkg::KIND_INSERT) begin
              write_slot_r <= write_slot_nxt;
              serial_r     <= serial_r + 32'd1;
              state_r      <= S_FINISH;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        S_FINISH: begin
          // The new entry is written this cycle; its serial goes out as the result.
          out_valid_r <= 1'b1;
          out_data_r  <= '{found: 1'b1, serial_number: serial_r};
          state_r     <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* sv/cbrt_ram.sv */
module cbrt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = cbrt_pkg::DEF_ENTRIES,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps

module testbench;

  localparam int TABLE_ENTRIES = cbrt_pkg::DEF_ENTRIES;
  localparam int RANDOM_BEATS  = 450;

  logic           clk;
  logic           rst_n;
  logic           start;
  logic           busy;
  cbrt_pkg::in_t  in_data;
  logic           out_valid;
  cbrt_pkg::out_t out_data;

  // Model of the table, kept in step with every accepted beat.
  logic [31:0] card_tab [TABLE_ENTRIES];
  logic [31:0] serial_tab [TABLE_ENTRIES];
  int unsigned last_slot;
  logic [31:0] serial_count;

  // Results still owed by the block, oldest first.
  cbrt_pkg::out_t owed_results [$];

  // Card IDs inserted lately, so that finds and deletes hit the table often.
  logic [31:0] recent_ids [$];

  int fail_count;

  card_blocklist_ring_table_core #(
    .ENTRIES(TABLE_ENTRIES)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  // Free-running clock with a 2 ns period.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard limit on the run, well beyond the slowest correct run.
  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

  // Clears every slot that holds the given card ID.
  function automatic void wipe_card(input logic [31:0] id);
    int i;
    for (i = 0; i < TABLE_ENTRIES; i++) begin
      if (card_tab[i] == id) begin
        card_tab[i] = '0;
        serial_tab[i] = '0;
      end
    end
  endfunction

  // Applies one beat to the table model; returns 1 when the block owes a result.
  function automatic bit apply_card_op(input cbrt_pkg::in_t beat, output cbrt_pkg::out_t res);
    int i;
    res = '0;
    case (beat.kind)
      cbrt_pkg::KIND_INSERT: begin
        wipe_card(beat.card_id);
        if (last_slot + 1 >= TABLE_ENTRIES) last_slot = 0;
        else last_slot = last_slot + 1;
        serial_count = serial_count + 32'd1;
        serial_tab[last_slot] = serial_count;
        card_tab[last_slot] = beat.card_id;
        res.found = 1'b1;
        res.serial_number = serial_count;
        return 1'b1;
      end
      cbrt_pkg::KIND_DELETE: begin
        wipe_card(beat.card_id);
        return 1'b0;
      end
      cbrt_pkg::KIND_FIND: begin
        for (i = 0; i < TABLE_ENTRIES; i++) begin
          if (card_tab[i] == beat.card_id) begin
            res.found = 1'b1;
            res.serial_number = serial_tab[i];
            return 1'b1;
          end
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Sends one beat. Called at a falling edge and returns at a falling edge.
  task automatic send_beat(input logic [1:0] kind, input logic [31:0] id);
    cbrt_pkg::in_t  beat;
    cbrt_pkg::out_t res;
    bit             owed;
    beat.kind = kind;
    beat.card_id = id;
    start = 1'b1;
    in_data = beat;
    do @(posedge clk); while (busy !== 1'b0);
    owed = apply_card_op(beat, res);
    if (owed) owed_results.push_back(res);
    if (kind == cbrt_pkg::KIND_INSERT) begin
      recent_ids.push_back(id);
      if (recent_ids.size() > 32) void'(recent_ids.pop_front());
    end
    @(negedge clk);
    start = 1'b0;
  endtask

  // Idles the sender for a random number of cycles, mostly short.
  task automatic idle_sender();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (r < 60) n = 0;
    else if (r < 90) n = $urandom_range(1, 4);
    else n = $urandom_range(20, 200);
    repeat (n) @(negedge clk);
  endtask

  // Holds the sender back until every owed result has arrived.
  task automatic wait_for_results();
    while (owed_results.size() != 0) @(negedge clk);
  endtask

  // Picks a card ID: often one inserted lately, sometimes an extreme value.
  function automatic logic [31:0] pick_card_id();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45 && recent_ids.size() != 0)
      return recent_ids[$urandom_range(0, recent_ids.size() - 1)];
    else if (r < 55) return 32'h0000_0000;
    else if (r < 60) return 32'hFFFF_FFFF;
    else return $urandom;
  endfunction

  // Result checker: each result beat is matched against the oldest owed result.
  always @(posedge clk) begin
    cbrt_pkg::out_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (owed_results.size() == 0) begin
        if (fail_count < 10)
          $display("unexpected result beat: found %0b serial %08h",
                   out_data.found, out_data.serial_number);
        fail_count++;
      end else begin
        want = owed_results.pop_front();
        if (out_data.found !== want.found) begin
          if (fail_count < 10)
            $display("found mismatch: expected %0b, got %0b", want.found, out_data.found);
          fail_count++;
        end
        if (out_data.serial_number !== want.serial_number) begin
          if (fail_count < 10)
            $display("serial mismatch: expected %08h, got %08h",
                     want.serial_number, out_data.serial_number);
          fail_count++;
        end
      end
    end
  end

  // An empty table matches ID 0 at slot 0 and misses everything else.
  task automatic test_empty_table();
    send_beat(cbrt_pkg::KIND_FIND, 32'h0000_0000);
    send_beat(cbrt_pkg::KIND_FIND, 32'hFFFF_FFFF);
    send_beat(cbrt_pkg::KIND_FIND, 32'h0000_0001);
  endtask

  // Inserts of extreme IDs, each found again with its serial.
  task automatic test_insert_and_find();
    send_beat(cbrt_pkg::KIND_INSERT, 32'hFFFF_FFFF);
    send_beat(cbrt_pkg::KIND_INSERT, 32'h0000_0001);
    send_beat(cbrt_pkg::KIND_INSERT, 32'h8000_0000);
    send_beat(cbrt_pkg::KIND_FIND, 32'hFFFF_FFFF);
    send_beat(cbrt_pkg::KIND_FIND, 32'h0000_0001);
    send_beat(cbrt_pkg::KIND_FIND, 32'h8000_0000);
    send_beat(cbrt_pkg::KIND_FIND, 32'h7FFF_FFFF);
  endtask

  // A second insert of the same ID drops the old entry and takes a new serial.
  task automatic test_reinsert();
    send_beat(cbrt_pkg::KIND_INSERT, 32'h0000_0001);
    send_beat(cbrt_pkg::KIND_FIND, 32'h0000_0001);
  endtask

  // Deletes of present and absent IDs, then a find of ID 0, which every empty slot matches.
  task automatic test_delete();
    send_beat(cbrt_pkg::KIND_DELETE, 32'hFFFF_FFFF);
    send_beat(cbrt_pkg::KIND_FIND, 32'hFFFF_FFFF);
    send_beat(cbrt_pkg::KIND_DELETE, 32'h1234_5678);
    send_beat(cbrt_pkg::KIND_FIND, 32'h0000_0000);
  endtask

  // Card ID 0 is the value of an empty slot.
  task automatic test_card_id_zero();
    send_beat(cbrt_pkg::KIND_INSERT, 32'h0000_0000);
    send_beat(cbrt_pkg::KIND_FIND, 32'h0000_0000);
    send_beat(cbrt_pkg::KIND_DELETE, 32'h0000_0000);
    send_beat(cbrt_pkg::KIND_FIND, 32'h0000_0000);
  endtask

  // The unused kind code is ignored and leaves the table as it was.
  task automatic test_unused_kind();
    send_beat(2'd3, 32'h0000_0001);
    send_beat(2'd3, 32'hFFFF_FFFF);
    send_beat(cbrt_pkg::KIND_FIND, 32'h0000_0001);
  endtask

  // Random mix of operations with random idling; ignored beats are not counted.
  task automatic test_random_ops(input int beats);
    int done;
    int r;
    bit quiet;
    logic [1:0] kind;
    done = 0;
    quiet = 1'b0;
    while (done < beats) begin
      if (done % 30 == 0) quiet = ($urandom_range(0, 2) == 0);
      r = $urandom_range(0, 99);
      if (r < 40) kind = cbrt_pkg::KIND_INSERT;
      else if (r < 55) kind = cbrt_pkg::KIND_DELETE;
      else if (r < 94) kind = cbrt_pkg::KIND_FIND;
      else kind = 2'd3;
      send_beat(kind, pick_card_id());
      if (kind != 2'd3) done++;
      if (!quiet) idle_sender();
    end
  endtask

  // The sender stops until the block has delivered every owed result.
  task automatic test_pause_until_drained();
    send_beat(cbrt_pkg::KIND_INSERT, $urandom);
    send_beat(cbrt_pkg::KIND_FIND, pick_card_id());
    wait_for_results();
    send_beat(cbrt_pkg::KIND_FIND, pick_card_id());
  endtask

  initial begin
    int i;
    start = 1'b0;
    in_data = '0;
    rst_n = 1'b0;
    fail_count = 0;
    last_slot = 0;
    serial_count = '0;
    for (i = 0; i < TABLE_ENTRIES; i++) begin
      card_tab[i] = '0;
      serial_tab[i] = '0;
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_table();
    test_insert_and_find();
    test_reinsert();
    test_delete();
    test_card_id_zero();
    test_unused_kind();
    test_random_ops(RANDOM_BEATS / 2);
    test_pause_until_drained();
    test_random_ops(RANDOM_BEATS / 2);

    // Let the last scan finish and catch any stray result beat.
    wait_for_results();
    repeat (TABLE_ENTRIES + 20) @(negedge clk);

    if (fail_count == 0 && owed_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
